// ----- rtl/parameter_ramp_engine_defines.svh -----
// Assertion macros shared by the parameter ramp engine RTL.
`ifndef PARAMETER_RAMP_ENGINE_DEFINES_SVH
`define PARAMETER_RAMP_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define PRMP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PRMP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/prmp_pkg.sv -----
// Types, codes and arithmetic helpers of the parameter ramp engine.
package prmp_pkg;

   localparam logic [2:0] CMD_DEFINE = 3'd0;
   localparam logic [2:0] CMD_RATE   = 3'd1;
   localparam logic [2:0] CMD_TARGET = 3'd2;
   localparam logic [2:0] CMD_APPLY  = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   localparam logic [1:0] CLK_SYNC  = 2'd0;
   localparam logic [1:0] CLK_AUDIO = 2'd1;
   localparam logic [1:0] CLK_FAST  = 2'd2;
   localparam logic [1:0] CLK_SLOW  = 2'd3;

   localparam logic [1:0] CSR_PRELOAD = 2'd0;
   localparam logic [1:0] CSR_FAST    = 2'd1;
   localparam logic [1:0] CSR_SLOW    = 2'd2;

   localparam logic [3:0] MODE_ADD     = 4'd0;
   localparam logic [3:0] MODE_MUL     = 4'd1;
   localparam logic [3:0] MODE_SUB     = 4'd2;
   localparam logic [3:0] MODE_SQ_ADD  = 4'd3;
   localparam logic [3:0] MODE_SQ_MUL  = 4'd4;
   localparam logic [3:0] MODE_CUB_ADD = 4'd5;
   localparam logic [3:0] MODE_SCURVE  = 4'd6;

   localparam logic [25:0] ONE_POS  = 26'h100_0000;
   localparam logic [24:0] ONE_RATE = 25'h100_0000;

   typedef struct packed {
      logic        [8:0]  base;
      logic        [1:0]  kind;
      logic        [24:0] norm;
      logic        [3:0]  mode;
      logic signed [31:0] offset;
   } head_type;

   typedef struct packed {
      logic signed [31:0] signal;
      logic signed [31:0] start;
      logic signed [32:0] diff;
      logic signed [31:0] target;
      logic        [25:0] position;
      logic        [24:0] rate_next;
      logic        [24:0] rate_run;
      logic               active;
      logic               pending;
   } slot_rec_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      if (x > 48'sh0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (x < 48'shFFFF_8000_0000) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   // Q24 product, floored.
   function automatic logic signed [41:0] mulq(input logic signed [32:0] x,
                                               input logic signed [32:0] y);
      logic signed [65:0] p;
      p = x * y;
      return p[65:24];
   endfunction

endpackage

// ----- rtl/prmp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module prmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/parameter_ramp_engine.sv -----
// Top level of the parameter ramp engine: head table, slot table and ramp arithmetic.
//
//  channel  dir  handshake            payload
//  req_     in   tvalid/tready        tuser cmd, tdata voice..scale_offset
//  rsp_     out  tvalid/tready        tdata signal, ramp_active, pending, bad_mode
//  csr_     in   we                   addr, wdata
//
// A request passes through these steps in order: accept with head read, slot read, scale prep, two passes
// through the shared 33x33 multiplier, then slot write-back into the result register.
// The slot RAM has one read and one write port; one request is in flight at a time.
// After reset a clearing pass writes NUM_SLOTS zero records, one a cycle, before
// the first request is taken. A new request is taken while a result waits; the
// write-back stage holds until the previous result has been taken.
`include "parameter_ramp_engine_defines.svh"

module parameter_ramp_engine #(
   parameter int NUM_PARAMS = 256,
   parameter int NUM_SLOTS  = 512,
   parameter int NUM_VOICES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // cmd
   // voice, param, value, base_slot, clock_kind, normalizer, scale_mode, scale_offset
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // signal, ramp_active, pending, bad_mode
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import prmp_pkg::*;

   localparam int PW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int HW = $bits(head_type);
   localparam int RW = $bits(slot_rec_type);

   // Q24 reciprocals, rounded up; exact for dividends below 2^10
   localparam logic [24:0] RCP_P = 25'((2**24 + NUM_PARAMS - 1) / NUM_PARAMS);
   localparam logic [24:0] RCP_V = 25'((2**24 + NUM_VOICES - 1) / NUM_VOICES);
   localparam logic [24:0] RCP_S = 25'((2**24 + NUM_SLOTS - 1) / NUM_SLOTS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HEAD  = 3'd2;
   localparam logic [2:0] S_SC0   = 3'd3;
   localparam logic [2:0] S_SC1   = 3'd4;
   localparam logic [2:0] S_SC2   = 3'd5;
   localparam logic [2:0] S_UPD   = 3'd6;

   // remainder by a constant through its reciprocal
   function automatic logic [11:0] mod_const(input logic [9:0] x, input logic [12:0] m,
                                             input logic [24:0] rcp);
      logic [34:0] prod;
      logic [9:0]  quo;
      logic [22:0] back;
      prod = 35'(x) * 35'(rcp);
      quo  = prod[33:24];
      back = 23'(quo) * 23'(m);
      return 12'(23'(x) - back);
   endfunction

   function automatic slot_rec_type apply_tgt(input slot_rec_type r, input logic [1:0] kind);
      slot_rec_type o;
      o = r;
      if (kind != CLK_SYNC) begin
         o.start    = r.signal;
         o.diff     = 33'(r.target) - 33'(r.signal);
         o.rate_run = r.rate_next;
         o.position = {1'b0, r.rate_next};
         o.active   = 1'b1;
      end else begin
         o.signal = r.target;
      end
      return o;
   endfunction

   logic [2:0]  state_ff, state_in;
   logic [SW-1:0] clr_cnt_ff, clr_cnt_in;

   logic        preload_ff;
   logic [15:0] fast_ff;
   logic [15:0] slow_ff;

   logic [2:0]         cmd_ff;
   logic [4:0]         voice_ff;
   logic signed [31:0] value_ff;
   head_type           def_ff;
   head_type           hd_ff;
   logic signed [31:0] v_ff;
   logic signed [31:0] w_ff;
   logic signed [32:0] av_ff;
   logic [SW-1:0]      slot_ff;
   logic signed [41:0] t1_ff;
   logic signed [41:0] t2_ff;

   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   // request fields
   logic [4:0]  in_voice;
   logic [7:0]  in_param;
   head_type    in_def;
   logic [11:0] pmod;
   logic [11:0] vmod;
   logic        accept;

   assign in_voice      = req_tdata[4:0];
   assign in_param      = req_tdata[12:5];
   assign in_def.base   = req_tdata[53:45];
   assign in_def.kind   = req_tdata[55:54];
   assign in_def.norm   = req_tdata[80:56];
   assign in_def.mode   = req_tdata[84:81];
   assign in_def.offset = req_tdata[116:85];

   assign pmod   = mod_const({2'b0, in_param}, 13'(NUM_PARAMS), RCP_P);
   assign vmod   = mod_const({5'b0, in_voice}, 13'(NUM_VOICES), RCP_V);
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // head table
   logic [HW-1:0] head_rd_raw;
   head_type      head_rd;
   assign head_rd = head_type'(head_rd_raw);

   prmp_ram #(.WIDTH(HW), .DEPTH(NUM_PARAMS)) u_head_ram (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == CMD_DEFINE)),
      .wr_addr (pmod[PW-1:0]),
      .wr_data (HW'(in_def)),
      .rd_en   (accept),
      .rd_addr (pmod[PW-1:0]),
      .rd_data (head_rd_raw)
   );

   // slot address from the head
   head_type    hd_cur;
   logic [11:0] smod;
   logic signed [31:0] v_cur;
   assign hd_cur = (cmd_ff == CMD_DEFINE) ? def_ff : head_rd;
   assign smod   = mod_const(10'(hd_cur.base) + 10'(voice_ff), 13'(NUM_SLOTS), RCP_S);
   assign v_cur  = sat32(48'(mulq(33'(value_ff), {8'b0, hd_cur.norm})));

   // slot table
   logic [RW-1:0] slot_rd_raw;
   slot_rec_type  rec;
   slot_rec_type  nrec;
   logic          out_free;
   logic          slot_we;
   logic [SW-1:0] slot_waddr;
   logic [RW-1:0] slot_wdata;

   assign rec        = slot_rec_type'(slot_rd_raw);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign slot_we    = (state_ff == S_CLEAR) || ((state_ff == S_UPD) && out_free);
   assign slot_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : slot_ff;
   assign slot_wdata = (state_ff == S_CLEAR) ? '0 : RW'(nrec);

   prmp_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (state_ff == S_HEAD),
      .rd_addr (smod[SW-1:0]),
      .rd_data (slot_rd_raw)
   );

   // shared multiplier
   logic [25:0]        pos_eff;
   logic signed [31:0] st1;
   logic signed [31:0] st2;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [41:0] mul_q;

   assign pos_eff = (rec.position >= ONE_POS) ? ONE_POS : rec.position;
   assign st1     = sat32(48'(t1_ff));
   assign st2     = sat32(48'(t2_ff));

   always_comb begin
      mul_a = 33'(v_ff);
      mul_b = 33'(hd_ff.offset);
      if (state_ff == S_SC1) begin
         if (cmd_ff == CMD_TICK) begin
            mul_a = rec.diff;
            mul_b = {7'b0, pos_eff};
         end else begin
            unique case (hd_ff.mode)
               MODE_SQ_ADD, MODE_SQ_MUL: begin
                  mul_a = av_ff;
                  mul_b = 33'(v_ff);
               end
               MODE_CUB_ADD: begin
                  mul_a = 33'(v_ff);
                  mul_b = 33'(v_ff);
               end
               MODE_SCURVE: begin
                  mul_a = 33'(w_ff);
                  mul_b = 33'(w_ff);
               end
               default: begin
                  mul_a = 33'(v_ff);
                  mul_b = 33'(hd_ff.offset);
               end
            endcase
         end
      end else begin
         mul_a = 33'(st1);
         unique case (hd_ff.mode)
            MODE_CUB_ADD: mul_b = 33'(v_ff);
            MODE_SCURVE:  mul_b = 33'(w_ff);
            default:      mul_b = 33'(hd_ff.offset);
         endcase
      end
   end

   assign mul_q = mulq(mul_a, mul_b);

   // write-back
   logic signed [31:0] tgt;
   logic signed [47:0] w3;
   logic [16:0]        factor;
   logic [47:0]        rate_raw;
   logic               bad;

   assign w3 = (48'(w_ff) <<< 1) + 48'(w_ff);

   always_comb begin
      unique case (hd_ff.mode)
         MODE_ADD:     tgt = sat32(48'(v_ff) + 48'(hd_ff.offset));
         MODE_MUL:     tgt = st1;
         MODE_SUB:     tgt = sat32(48'(hd_ff.offset) - 48'(v_ff));
         MODE_SQ_ADD:  tgt = sat32(48'(st1) + 48'(hd_ff.offset));
         MODE_SQ_MUL:  tgt = st2;
         MODE_CUB_ADD: tgt = sat32(48'(st2) + 48'(hd_ff.offset));
         default:      tgt = sat32(48'(st2) - 48'sh40_0000 + (w3 >>> 2) + 48'sh80_0000);
      endcase
   end

   always_comb begin
      unique case (hd_ff.kind)
         CLK_SYNC:  factor = 17'd0;
         CLK_AUDIO: factor = 17'd1;
         CLK_FAST:  factor = {1'b0, fast_ff};
         default:   factor = {1'b0, slow_ff};
      endcase
      rate_raw = value_ff[31] ? 48'd0 : 48'(value_ff[30:0]) * 48'(factor);
   end

   always_comb begin
      nrec = rec;
      bad  = 1'b0;
      unique case (cmd_ff)
         CMD_RATE: begin
            nrec.rate_next = (rate_raw > 48'(ONE_RATE)) ? ONE_RATE : rate_raw[24:0];
         end
         CMD_TARGET: begin
            if (hd_ff.mode > MODE_SCURVE) begin
               bad = 1'b1;
            end else begin
               nrec.target = tgt;
               if (!preload_ff) begin
                  nrec = apply_tgt(nrec, hd_ff.kind);
               end else begin
                  nrec.pending = 1'b1;
               end
            end
         end
         CMD_APPLY: begin
            if (rec.pending) begin
               nrec.pending = 1'b0;
               nrec = apply_tgt(nrec, hd_ff.kind);
            end
         end
         CMD_TICK: begin
            if (rec.active) begin
               if (rec.position >= ONE_POS) begin
                  nrec.active = 1'b0;
               end
               nrec.signal   = sat32(48'(rec.start) + 48'(t1_ff));
               nrec.position = pos_eff + {1'b0, rec.rate_run};
            end
         end
         default: begin
            nrec = rec;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SW'(NUM_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE:  if (accept) state_in = S_HEAD;
         S_HEAD:  state_in = S_SC0;
         S_SC0:   state_in = S_SC1;
         S_SC1:   state_in = S_SC2;
         S_SC2:   state_in = S_UPD;
         S_UPD:   if (out_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         preload_ff   <= 1'b0;
         fast_ff      <= 16'd1;
         slow_ff      <= 16'd1;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         if ((state_ff == S_UPD) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_PRELOAD: preload_ff <= csr_wdata[0];
               CSR_FAST:    fast_ff    <= csr_wdata;
               CSR_SLOW:    slow_ff    <= csr_wdata;
               default:     preload_ff <= preload_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tuser;
         voice_ff <= vmod[4:0];
         value_ff <= req_tdata[44:13];
         def_ff   <= in_def;
      end
      if (state_ff == S_HEAD) begin
         hd_ff   <= hd_cur;
         v_ff    <= v_cur;
         slot_ff <= smod[SW-1:0];
      end
      if (state_ff == S_SC0) begin
         w_ff  <= sat32(((48'(hd_ff.offset) - 48'(v_ff)) <<< 1) - 48'sh100_0000);
         av_ff <= v_ff[31] ? -33'(v_ff) : 33'(v_ff);
      end
      if (state_ff == S_SC1) begin
         t1_ff <= mul_q;
      end
      if (state_ff == S_SC2) begin
         t2_ff <= mul_q;
      end
      if ((state_ff == S_UPD) && out_free) begin
         rsp_data_ff <= {5'b0, bad, nrec.pending, nrec.active, nrec.signal};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PRMP_ASSERT_NXT(a_accept_to_head, clock, reset, accept, state_ff == S_HEAD,
                    "accepted request did not start a head lookup")
   `PRMP_ASSERT_NXT(a_wb_holds, clock, reset, (state_ff == S_UPD) && !out_free,
                    (state_ff == S_UPD) && rsp_tvalid, "write-back left while result blocked")
   `PRMP_ASSERT_NXT(a_wb_result, clock, reset, (state_ff == S_UPD) && out_free,
                    rsp_tvalid && (state_ff == S_IDLE), "write-back produced no result")
   `PRMP_ASSERT_NOW(a_slot_wr_state, clock, reset, slot_we,
                    (state_ff == S_CLEAR) || (state_ff == S_UPD),
                    "slot write outside clear or write-back")

endmodule

// ----- tb/sv/parameter_ramp_engine_tb.sv -----
// Self-checking testbench for the parameter ramp engine: random and directed requests.
module parameter_ramp_engine_tb;
   import prmp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_READ     = 3'd5;
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam logic [3:0] MODE_BAD_LO  = 4'd7;
   localparam logic [3:0] MODE_BAD_HI  = 4'd15;
   localparam longint     Q_ONE        = 64'sh100_0000;
   localparam int         STALL_LIMIT  = 5000;
   localparam int         HOLD_CYCLES  = 300;

   typedef struct {
      logic [2:0]  cmd;
      logic [4:0]  voice;
      logic [7:0]  param;
      logic [31:0] value;
      logic [8:0]  base;
      logic [1:0]  kind;
      logic [24:0] norm;
      logic [3:0]  mode;
      logic [31:0] offset;
   } ramp_request;

   typedef struct {
      logic [31:0] signal;
      bit          active;
      bit          pending;
      bit          bad;
   } slot_view;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [2:0]   req_tuser = '0;
   logic [119:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [15:0]  csr_wdata = '0;

   parameter_ramp_engine uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [8:0]  hd_base [256];
   logic [1:0]  hd_kind [256];
   logic [24:0] hd_norm [256];
   logic [3:0]  hd_mode [256];
   longint      hd_offset [256];
   longint      sl_signal [512];
   longint      sl_start [512];
   longint      sl_diff [512];
   longint      sl_target [512];
   longint      sl_pos [512];
   longint      sl_rate_next [512];
   longint      sl_rate_run [512];
   bit          sl_active [512];
   bit          sl_pending [512];
   bit          preload;
   longint      fast_factor = 1;
   longint      slow_factor = 1;

   ramp_request pending_q[$];
   slot_view    expect_q[$];
   ramp_request req_cur;
   logic [7:0]  defined_params[$];
   int          errors = 0;
   int          cycle = 0;
   int          stall = 0;
   bit          hold_wanted = 0;
   bit          hold_done = 0;
   int          hold_count = 0;
   logic [7:0]  focus_param = 0;
   logic [4:0]  focus_voice = 0;

   function automatic longint clip32(longint x);
      if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return -64'sh8000_0000;
      return x;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 24;
   endfunction

   function automatic longint curve(logic [3:0] mode, longint a, longint v);
      longint av;
      longint w;
      av = v < 0 ? -v : v;
      case (mode)
         MODE_ADD:     return clip32(v + a);
         MODE_MUL:     return clip32(qmul(v, a));
         MODE_SUB:     return clip32(a - v);
         MODE_SQ_ADD:  return clip32(clip32(qmul(av, v)) + a);
         MODE_SQ_MUL:  return clip32(qmul(clip32(qmul(av, v)), a));
         MODE_CUB_ADD: return clip32(clip32(qmul(clip32(qmul(v, v)), v)) + a);
         default: begin
            w = clip32(2 * (a - v) - Q_ONE);
            return clip32(clip32(qmul(clip32(qmul(w, w)), w)) - 64'sh40_0000
                          + qmul(w, 64'shC0_0000) + 64'sh80_0000);
         end
      endcase
   endfunction

   function automatic void launch(logic [8:0] s, logic [1:0] kind);
      if (kind != CLK_SYNC) begin
         sl_start[s] = sl_signal[s];
         sl_diff[s] = sl_target[s] - sl_start[s];
         sl_rate_run[s] = sl_rate_next[s];
         sl_pos[s] = sl_rate_next[s];
         sl_active[s] = 1;
      end else begin
         sl_signal[s] = sl_target[s];
      end
   endfunction

   function automatic slot_view predict_slot(ramp_request r);
      slot_view   o;
      logic [8:0] s;
      longint     factor;
      longint     rate;
      logic [7:0] p;
      p = r.param;
      o.bad = 0;
      if (r.cmd == CMD_DEFINE) begin
         hd_base[p] = r.base;
         hd_kind[p] = r.kind;
         hd_norm[p] = r.norm;
         hd_mode[p] = r.mode;
         hd_offset[p] = longint'($signed(r.offset));
      end
      s = hd_base[p] + r.voice;
      case (r.cmd)
         CMD_RATE: begin
            case (hd_kind[p])
               CLK_SYNC:  factor = 0;
               CLK_AUDIO: factor = 1;
               CLK_FAST:  factor = fast_factor;
               default:   factor = slow_factor;
            endcase
            rate = $signed(r.value) < 0 ? 0 : longint'($signed(r.value)) * factor;
            sl_rate_next[s] = rate > Q_ONE ? Q_ONE : rate;
         end
         CMD_TARGET: begin
            if (hd_mode[p] >= MODE_BAD_LO) begin
               o.bad = 1;
            end else begin
               sl_target[s] = curve(hd_mode[p], hd_offset[p],
                  clip32(qmul(longint'($signed(r.value)), longint'(hd_norm[p]))));
               if (!preload) launch(s, hd_kind[p]);
               else sl_pending[s] = 1;
            end
         end
         CMD_APPLY: begin
            if (sl_pending[s]) begin
               sl_pending[s] = 0;
               launch(s, hd_kind[p]);
            end
         end
         CMD_TICK: begin
            if (sl_active[s]) begin
               if (sl_pos[s] >= Q_ONE) begin
                  sl_pos[s] = Q_ONE;
                  sl_active[s] = 0;
               end
               sl_signal[s] = clip32(sl_start[s] + qmul(sl_diff[s], sl_pos[s]));
               sl_pos[s] = (sl_pos[s] + sl_rate_run[s]) & 64'h3FF_FFFF;
            end
         end
         default: ;
      endcase
      o.signal = sl_signal[s][31:0];
      o.active = sl_active[s];
      o.pending = sl_pending[s];
      return o;
   endfunction

   function automatic ramp_request define_req(logic [7:0] p, logic [8:0] base,
                                              logic [1:0] kind, logic [24:0] norm,
                                              logic [3:0] mode, logic [31:0] offset);
      ramp_request r;
      r = '{CMD_DEFINE, 5'($urandom), p, $urandom, base, kind, norm, mode, offset};
      return r;
   endfunction

   function automatic ramp_request op_req(logic [2:0] cmd, logic [7:0] p,
                                          logic [4:0] voice, logic [31:0] value);
      ramp_request r;
      // define-only fields carry noise on other commands
      r = '{cmd, voice, p, value, 9'($urandom), 2'($urandom), 25'($urandom),
            4'($urandom), $urandom};
      return r;
   endfunction

   function automatic ramp_request random_req();
      int          pick;
      logic [2:0]  cmd;
      logic [31:0] value;
      ramp_request r;
      pick = $urandom_range(99);
      if (pick < 6) begin
         r = define_req(8'($urandom), 9'($urandom), 2'($urandom),
                        $urandom_range(3) == 0 ? 25'h100_0000 : 25'($urandom_range(24'hFF_FFFF)),
                        $urandom_range(9) == 0 ? 4'($urandom_range(MODE_BAD_HI, MODE_BAD_LO))
                                               : 4'($urandom_range(MODE_SCURVE)),
                        $urandom_range(1) ? $urandom : 32'($signed($urandom_range(32'h400_0000)) -
                                                             32'sh200_0000));
         defined_params.push_back(r.param);
         return r;
      end
      if ($urandom_range(99) < 30) begin
         focus_param = defined_params[$urandom_range(defined_params.size() - 1)];
         focus_voice = 5'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 15)      cmd = CMD_RATE;
      else if (pick < 35) cmd = CMD_TARGET;
      else if (pick < 45) cmd = CMD_APPLY;
      else if (pick < 88) cmd = CMD_TICK;
      else if (pick < 96) cmd = CMD_READ;
      else                cmd = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      if (cmd == CMD_RATE && $urandom_range(3) != 0) value = $urandom_range(32'h20_0000);
      else if (cmd == CMD_TARGET && $urandom_range(1)) value = $urandom_range(32'h800_0000) - 32'h400_0000;
      else value = $urandom;
      return op_req(cmd, focus_param, focus_voice, value);
   endfunction

   // request driver; req_cur follows the request on the bus
   always @(posedge clock) begin
      ramp_request nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_q.size() != 0 &&
             ((cycle > 2000 && cycle < 3000) || $urandom_range(99) >= 30)) begin
            nxt = pending_q.pop_front();
            req_cur <= nxt;
            req_tvalid <= 1'b1;
            req_tuser <= nxt.cmd;
            req_tdata <= {3'b0, nxt.offset, nxt.mode, nxt.norm, nxt.kind,
                          nxt.base, nxt.value, nxt.param, nxt.voice};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES) hold_done <= 1;
      end else begin
         rsp_tready <= (cycle > 2000 && cycle < 3000) || $urandom_range(99) >= 30;
      end
   end

   // predict on request accept, check on result accept
   always @(posedge clock) begin
      slot_view got;
      slot_view want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.signal = rsp_tdata[31:0];
            got.active = rsp_tdata[32];
            got.pending = rsp_tdata[33];
            got.bad = rsp_tdata[34];
            if (expect_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               want = expect_q.pop_front();
               if (got.signal !== want.signal || got.active !== want.active ||
                   got.pending !== want.pending || got.bad !== want.bad) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp sig=%h act=%b pend=%b bad=%b, got sig=%h act=%b pend=%b bad=%b",
                              want.signal, want.active, want.pending, want.bad,
                              got.signal, got.active, got.pending, got.bad);
               end
            end
         end
         if (req_tvalid && req_tready) expect_q.push_back(predict_slot(req_cur));
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall <= 0;
      else stall <= stall + 1;
      if (stall == STALL_LIMIT) begin
         $display("parameter_ramp_engine_tb: done, errors");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] addr, logic [15:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_PRELOAD: preload = data[0];
         CSR_FAST:    fast_factor = data;
         default:     slow_factor = data;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_tvalid || expect_q.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      repeat (count) pending_q.push_back(random_req());
      drain();
   endtask

   initial begin
      for (int i = 0; i < 512; i++) begin
         sl_signal[i] = 0; sl_start[i] = 0; sl_diff[i] = 0; sl_target[i] = 0;
         sl_pos[i] = 0; sl_rate_next[i] = 0; sl_rate_run[i] = 0;
         sl_active[i] = 0; sl_pending[i] = 0;
      end
      preload = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_PRELOAD, 16'd0);
      write_reg(CSR_FAST, 16'd1);
      write_reg(CSR_SLOW, 16'd1);

      // directed: extreme heads, every scale curve defined (all but SUB targeted), wrap, clipping, odd commands
      pending_q.push_back(define_req(8'd0, 9'd0, CLK_SYNC, 25'h100_0000, MODE_ADD, 32'h0));
      pending_q.push_back(define_req(8'd255, 9'd511, CLK_AUDIO, 25'h80_0000, MODE_SCURVE,
                                     32'h7FFF_FFFF));
      pending_q.push_back(define_req(8'd1, 9'd100, CLK_FAST, 25'h1FF_FFFF & 25'hFF_FFFF,
                                     MODE_MUL, 32'h8000_0000));
      pending_q.push_back(define_req(8'd2, 9'd200, CLK_SLOW, 25'h0, MODE_SUB, 32'h100_0000));
      pending_q.push_back(define_req(8'd3, 9'd300, CLK_AUDIO, 25'h100_0000, MODE_SQ_ADD,
                                     32'hFF00_0000));
      pending_q.push_back(define_req(8'd4, 9'd400, CLK_FAST, 25'h100_0000, MODE_SQ_MUL,
                                     32'h200_0000));
      pending_q.push_back(define_req(8'd5, 9'd450, CLK_SYNC, 25'h100_0000, MODE_CUB_ADD,
                                     32'h7FFF_FFFF));
      pending_q.push_back(define_req(8'd6, 9'd50, CLK_AUDIO, 25'h100_0000, MODE_BAD_HI, 32'h0));
      for (int p = 0; p < 7; p++) defined_params.push_back(8'(p));
      defined_params.push_back(8'd255);
      pending_q.push_back(op_req(CMD_RATE, 8'd255, 5'd31, 32'h8000_0000));  // negative rate
      pending_q.push_back(op_req(CMD_TARGET, 8'd255, 5'd31, 32'h7FFF_FFFF)); // zero-rate ramp
      pending_q.push_back(op_req(CMD_TICK, 8'd255, 5'd31, 32'h0));
      pending_q.push_back(op_req(CMD_RATE, 8'd1, 5'd0, 32'h7FFF_FFFF));      // clips to one
      pending_q.push_back(op_req(CMD_TARGET, 8'd1, 5'd0, 32'h8000_0000));
      pending_q.push_back(op_req(CMD_TICK, 8'd1, 5'd0, 32'h0));
      pending_q.push_back(op_req(CMD_TICK, 8'd1, 5'd0, 32'h0));
      pending_q.push_back(op_req(CMD_TICK, 8'd2, 5'd3, 32'h0));              // idle slot
      pending_q.push_back(op_req(CMD_APPLY, 8'd3, 5'd7, 32'h0));             // nothing pending
      pending_q.push_back(op_req(CMD_TARGET, 8'd0, 5'd0, 32'h7FFF_FFFF));
      pending_q.push_back(op_req(CMD_TARGET, 8'd3, 5'd1, 32'h8000_0000));
      pending_q.push_back(op_req(CMD_TARGET, 8'd4, 5'd2, 32'h0300_0000));
      pending_q.push_back(op_req(CMD_TARGET, 8'd5, 5'd9, 32'h8000_0000));
      pending_q.push_back(op_req(CMD_TARGET, 8'd6, 5'd4, 32'h1234_5678));    // bad curve
      pending_q.push_back(op_req(CMD_READ, 8'd2, 5'd31, $urandom));
      pending_q.push_back(op_req(CMD_SPARE_LO, 8'd0, 5'd0, $urandom));
      pending_q.push_back(op_req(CMD_SPARE_HI, 8'd255, 5'd31, $urandom));
      drain();

      write_reg(CSR_FAST, 16'hFFFF);
      write_reg(CSR_SLOW, 16'd300);
      random_phase(200);

      write_reg(CSR_PRELOAD, 16'd1);
      write_reg(CSR_FAST, 16'd0);
      write_reg(CSR_SLOW, 16'd2);
      hold_wanted = 1;
      random_phase(200);

      write_reg(CSR_FAST, 16'hFFFF);
      write_reg(CSR_SLOW, 16'hFFFF);
      random_phase(200);

      write_reg(CSR_PRELOAD, 16'd0);
      write_reg(CSR_FAST, 16'd3);
      write_reg(CSR_SLOW, 16'd0);
      random_phase(200);

      if (errors == 0) begin
         $display("parameter_ramp_engine_tb: done, clean");
      end else begin
         $display("parameter_ramp_engine_tb: done, errors");
      end
      $finish;
   end

endmodule
